/* rtl/cgbi_pkg.sv */
// Shared types, constants and the channel lerp for the colour gradient block.
// No dependencies; imported by every module of the block.
package cgbi_pkg;

    // Table depth default and fixed-point constants
    localparam int unsigned KEYS_DEFAULT = 16;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [16:0] SEG_MIN_Q16  = 17'd65;
    localparam logic [31:0] T_NONE       = 32'hFFFF_FFFF;
    localparam logic [31:0] DEFAULT_COLOR_RST = 32'hFFFF_FFFF;

    // Shared divider geometry: 33-bit dividend, 17-bit divisor, one bit a cycle
    localparam int unsigned DIV_W     = 33;
    localparam int unsigned DSR_W     = 17;
    localparam int unsigned DIV_STEPS = DIV_W;

    // Configuration register indexes
    localparam logic CFG_VERTEX_COUNT  = 1'b0;
    localparam logic CFG_DEFAULT_COLOR = 1'b1;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  vertex_index;
        logic [16:0] vertex_time;
        logic [31:0] vertex_min_color;
        logic [31:0] vertex_max_color;
        logic [15:0] age;
        logic [15:0] lifetime;
        logic [16:0] random_factor;
    } req_t;

    typedef struct packed {
        logic [31:0] color;
        logic        hit;
    } res_t;

    // a + trunc((b - a) * k / 65536), quotient rounded toward zero
    function automatic logic [7:0] cgbi_lerp8(input logic [7:0] a, input logic [7:0] b,
                                              input logic [16:0] k);
        logic signed [8:0]  d;
        logic signed [26:0] p;
        logic [25:0]        mag;
        logic [8:0]         q;
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        p   = d * $signed({1'b0, k});
        mag = p[26] ? 26'(-p) : p[25:0];
        q   = 9'(mag >> 16);
        return p[26] ? 8'(a - q[7:0]) : 8'(a + q[7:0]);
    endfunction

endpackage

/* rtl/cgbi_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cgbi_pkg for its widths.
module cgbi_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cgbi_pkg::DIV_W-1:0] dividend,
    input  logic [cgbi_pkg::DSR_W-1:0] divisor,
    output logic                      done,
    output logic [cgbi_pkg::DIV_W-1:0] quotient
);
    import cgbi_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic [DIV_W-1:0] dvd_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   rem_diff;
    logic             ge;

    // One trial subtraction
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
        rem_diff = rem_sh - {1'b0, dsr_reg};
        ge       = rem_sh >= {1'b0, dsr_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* rtl/color_gradient_band_interpolator_top.sv */
// Top level of the piecewise linear colour gradient with min and max bands.
// Depends on cgbi_pkg and cgbi_div.
//
// Usage
//   Items enter on start/req while busy is low. A write item (kind 0) stores
//   one keyframe in the same cycle and leaves busy low; it gives no result.
//   An evaluate item (kind 1) raises busy and yields one beat on done/result.
//   Registers vertex_count and default_color are written over cfg_valid /
//   cfg_index / cfg_data; cfg_ready is always high. Write them while idle.
// Steps of an evaluate item, using the shared divider and the lerp unit:
//   division of age by lifetime (skipped on zero lifetime),
//   a read state and a compare state per keyframe scanned, entry 0 included,
//   the blend division when the segment is long enough,
//   the channel lerps (one 8-bit channel per cycle), then the beat.
//   Shortest with fewer than two keys and zero lifetime, longest on a hit on
//   the last segment of a full table; one item is worked on at a time.
// done is high for one cycle with the result; the receiver cannot stall it.
// Reset clears control and vertex_count and sets default_color to all ones;
// the keyframe table is undefined until written.
module color_gradient_band_interpolator_top #(
    parameter int unsigned MAX_KEYS = cgbi_pkg::KEYS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  cgbi_pkg::req_t req,
    output logic           done,
    output cgbi_pkg::res_t result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_data
);
    import cgbi_pkg::*;

    localparam int unsigned IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);

    // Sequencer states
    localparam int unsigned ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [ST_W-1:0] ST_DIV_T    = 3'd1;
    localparam logic [ST_W-1:0] ST_SCAN_RD  = 3'd2;
    localparam logic [ST_W-1:0] ST_SCAN_CMP = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV_B    = 3'd4;
    localparam logic [ST_W-1:0] ST_LERP     = 3'd5;

    // Lerp phases
    localparam logic [1:0] LP_LO  = 2'd0;
    localparam logic [1:0] LP_HI  = 2'd1;
    localparam logic [1:0] LP_OUT = 2'd2;

    logic [ST_W-1:0] state_reg, state_next;

    logic [4:0]  vertex_count_reg;
    logic [31:0] default_color_reg;

    // Keyframe table
    logic [16:0] key_times      [MAX_KEYS];
    logic [31:0] key_min_colors [MAX_KEYS];
    logic [31:0] key_max_colors [MAX_KEYS];
    logic [16:0] rd_time_reg;
    logic [31:0] rd_min_reg;
    logic [31:0] rd_max_reg;

    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      t_reg;
    logic [16:0]      kf_reg;
    logic [16:0]      blend_reg;
    logic [16:0]      prev_time_reg;
    logic [31:0]      amin_reg, amax_reg;
    logic [31:0]      lo_reg, hi_reg, col_reg;
    logic [1:0]       lph_reg, lch_reg;
    logic             done_reg;
    res_t             result_reg;

    logic             accept, eval_go, wr_go, wr_ok;
    logic             match, last_key;
    logic [16:0]      seg, tdiff;
    logic [CNT_W-1:0] cnt_eff;
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_quotient;
    logic [DSR_W-1:0] div_divisor;
    logic [31:0]      la_word, lb_word;
    logic [16:0]      lk;
    logic [7:0]       lerp_res;

    assign accept  = start && !busy;
    assign eval_go = accept && (req.kind == KIND_EVAL);
    assign wr_go   = accept && (req.kind == KIND_WRITE);
    assign wr_ok   = 32'(req.vertex_index) < MAX_KEYS;
    assign cnt_eff = (32'(vertex_count_reg) > MAX_KEYS) ? CNT_W'(MAX_KEYS)
                                                       : CNT_W'(vertex_count_reg);

    // Segment test on the entry pair (ptr-1, ptr)
    assign seg      = rd_time_reg - prev_time_reg;
    assign tdiff    = 17'(t_reg) - prev_time_reg;
    assign match    = (ptr_reg != '0) && (32'(prev_time_reg) <= t_reg)
                      && (t_reg <= 32'(rd_time_reg));
    assign last_key = CNT_W'(ptr_reg + 1'b1) >= cnt_reg;

    // Divider operand select and launch
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            div_dividend = {1'b0, req.age, 16'h0000};
            div_divisor  = {1'b0, req.lifetime};
            div_start    = eval_go && (req.lifetime != '0);
        end
        else
        begin
            div_dividend = {tdiff, 16'h0000};
            div_divisor  = seg;
            div_start    = (state_reg == ST_SCAN_CMP) && match && (seg > SEG_MIN_Q16);
        end
    end

    cgbi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Table write and registered read at the scan pointer
    always_ff @(posedge clk)
    begin
        if (wr_go && wr_ok)
        begin
            key_times[IDX_W'(req.vertex_index)]      <= req.vertex_time;
            key_min_colors[IDX_W'(req.vertex_index)] <= req.vertex_min_color;
            key_max_colors[IDX_W'(req.vertex_index)] <= req.vertex_max_color;
        end
        rd_time_reg <= key_times[ptr_reg[IDX_W-1:0]];
        rd_min_reg  <= key_min_colors[ptr_reg[IDX_W-1:0]];
        rd_max_reg  <= key_max_colors[ptr_reg[IDX_W-1:0]];
    end

    // Shared channel lerp operands
    always_comb
    begin
        case (lph_reg)
            LP_LO:
            begin
                la_word = amin_reg;
                lb_word = rd_min_reg;
                lk      = blend_reg;
            end
            LP_HI:
            begin
                la_word = amax_reg;
                lb_word = rd_max_reg;
                lk      = blend_reg;
            end
            default:
            begin
                la_word = lo_reg;
                lb_word = hi_reg;
                lk      = kf_reg;
            end
        endcase
        lerp_res = cgbi_lerp8(la_word[{lch_reg, 3'b000} +: 8],
                              lb_word[{lch_reg, 3'b000} +: 8], lk);
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (eval_go)
                    state_next = (req.lifetime != '0) ? ST_DIV_T : ST_SCAN_RD;
            ST_DIV_T:
                if (div_done)
                    state_next = ST_SCAN_RD;
            ST_SCAN_RD:
                state_next = (cnt_reg < CNT_W'(2)) ? ST_IDLE : ST_SCAN_CMP;
            ST_SCAN_CMP:
                if (match)
                    state_next = (seg > SEG_MIN_Q16) ? ST_DIV_B : ST_LERP;
                else if (last_key)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SCAN_RD;
            ST_DIV_B:
                if (div_done)
                    state_next = ST_LERP;
            ST_LERP:
                if (lph_reg == LP_OUT && lch_reg == 2'd3)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            vertex_count_reg  <= '0;
            default_color_reg <= DEFAULT_COLOR_RST;
            done_reg          <= 1'b0;
            ptr_reg           <= '0;
            lph_reg           <= LP_LO;
            lch_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_data[4:0];
                    CFG_DEFAULT_COLOR: default_color_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                    ptr_reg <= '0;
                ST_SCAN_RD:
                    if (cnt_reg < CNT_W'(2))
                        done_reg <= 1'b1;
                ST_SCAN_CMP:
                begin
                    lph_reg <= LP_LO;
                    lch_reg <= '0;
                    if (!match && last_key)
                        done_reg <= 1'b1;
                    else if (!match)
                        ptr_reg <= ptr_reg + 1'b1;
                end
                ST_LERP:
                begin
                    lch_reg <= lch_reg + 1'b1;
                    if (lch_reg == 2'd3)
                    begin
                        lph_reg <= lph_reg + 1'b1;
                        if (lph_reg == LP_OUT)
                            done_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (eval_go)
                begin
                    kf_reg  <= (req.random_factor > ONE_Q16) ? ONE_Q16 : req.random_factor;
                    t_reg   <= T_NONE;
                    cnt_reg <= cnt_eff;
                end
            ST_DIV_T:
                if (div_done)
                    t_reg <= div_quotient[31:0];
            ST_SCAN_RD:
                if (cnt_reg < CNT_W'(2))
                    result_reg <= '{color: default_color_reg, hit: 1'b0};
            ST_SCAN_CMP:
            begin
                blend_reg <= '0;
                if (!match)
                begin
                    prev_time_reg <= rd_time_reg;
                    amin_reg      <= rd_min_reg;
                    amax_reg      <= rd_max_reg;
                    if (last_key)
                        result_reg <= '{color: default_color_reg, hit: 1'b0};
                end
            end
            ST_DIV_B:
                if (div_done)
                    blend_reg <= div_quotient[16:0];
            ST_LERP:
            begin
                case (lph_reg)
                    LP_LO: lo_reg[{lch_reg, 3'b000} +: 8] <= lerp_res;
                    LP_HI: hi_reg[{lch_reg, 3'b000} +: 8] <= lerp_res;
                    default:
                    begin
                        col_reg[{lch_reg, 3'b000} +: 8] <= lerp_res;
                        if (lch_reg == 2'd3)
                            result_reg <= '{color: {lerp_res, col_reg[23:0]}, hit: 1'b1};
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

endmodule

/* rtl/cgbi_chk.sv */
// Port-level checker for the colour gradient block, bound to the top level.
// Depends on cgbi_pkg for the result type.
module cgbi_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input cgbi_pkg::res_t result
);
    import cgbi_pkg::*;

    // A result beat closes the evaluation: busy has dropped
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result beat while still busy");

    // Every result beat follows a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result beat without an evaluation");

    // One beat per evaluation
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result beat repeated");

    // Busy only rises on an accepted item
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without start");

    // On a result beat the hit flag is never unknown
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result.hit)) else $error("hit flag unknown");

endmodule

bind color_gradient_band_interpolator_top cgbi_chk u_cgbi_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
